@@ hw/rtl/i2cbr_pkg.sv @@
package i2cbr_pkg;

   localparam int COUNT_WIDTH = 24;

   localparam logic [1:0] CsrSettle  = 2'd0;
   localparam logic [1:0] CsrHalf    = 2'd1;
   localparam logic [1:0] CsrStretch = 2'd2;
   localparam logic [1:0] CsrPulses  = 2'd3;

   localparam logic [1:0] OutCleared    = 2'd0;
   localparam logic [1:0] OutSclStuck   = 2'd1;
   localparam logic [1:0] OutStretchTmo = 2'd2;
   localparam logic [1:0] OutSdaStuck   = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic start_request;
      logic scl_level;
      logic sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       finished;
      logic [1:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic [23:0] settle_ticks;
      logic [15:0] half_period_ticks;
      logic [23:0] stretch_timeout_ticks;
      logic [4:0]  max_pulses;
   } cfg_type;

   // limit clipped to the counter range
   function automatic logic [COUNT_WIDTH-1:0] sat_limit(input logic [23:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(CountMax)) begin
         return CountMax;
      end
      return COUNT_WIDTH'(v);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      if (c == CountMax) begin
         return CountMax;
      end
      return c + 1'b1;
   endfunction

endpackage

@@ hw/rtl/i2c_bus_recovery_sequencer_top.sv @@
// i2c bus-clear recovery sequencer
// req channel: one word per time tick with the sampled scl/sda levels and a
// start request; a start is taken only while idle and runs the settle, scl
// check, up to max_pulses scl pulses with stretch wait, and start/stop phases
// rsp channel: one word per req word with the open-drain drive levels, busy,
// a one-word finished flag and the outcome of the latest sequence
// a req word is registered in the input register on accept and evaluated
// against the sequencer state when it advances; the rsp register then loads
// the result and raises rsp valid
// one word per cycle while rsp_stall stays low; the state update lies
// between the input register and the rsp register
// csr port: write settle, half period, stretch timeout and max pulses at
// indexes 0..3; write only while the block is idle
// reset (synchronous): sequencer idle, outcome cleared, registers at their
// defaults, both stages empty
// rsp_stall holds the rsp register; the input register then fills and
// req_stall rises until the rsp word is taken, with no word lost
module i2c_bus_recovery_sequencer_top
   import i2cbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   cfg_type cfg_ff;
   rsp_type seq_result;
   logic    advance;
   logic    req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   i2cbr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks          <= 24'd2500000;
         cfg_ff.half_period_ticks     <= 16'd10;
         cfg_ff.stretch_timeout_ticks <= 24'd2000000;
         cfg_ff.max_pulses            <= 5'd20;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrSettle:  cfg_ff.settle_ticks          <= csr_write_data;
            CsrHalf:    cfg_ff.half_period_ticks     <= csr_write_data[15:0];
            CsrStretch: cfg_ff.stretch_timeout_ticks <= csr_write_data;
            CsrPulses:  cfg_ff.max_pulses            <= csr_write_data[4:0];
            default:    cfg_ff.max_pulses            <= cfg_ff.max_pulses;
         endcase
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_take)
      else $error("input word overwritten before use");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled rsp word lost");

   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated word not registered");

endmodule

@@ hw/rtl/i2cbr_seq.sv @@
module i2cbr_seq
   import i2cbr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [2:0] PhIdle      = 3'd0;
   localparam logic [2:0] PhSettle    = 3'd1;
   localparam logic [2:0] PhPulseLow  = 3'd2;
   localparam logic [2:0] PhPulseHigh = 3'd3;
   localparam logic [2:0] PhStretch   = 3'd4;
   localparam logic [2:0] PhStart     = 3'd5;
   localparam logic [2:0] PhStop      = 3'd6;

   logic [2:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [4:0]             pulses_ff, pulses_in;
   logic [1:0]             outcome_ff, outcome_in;

   logic                   fin;
   logic [1:0]             status;
   logic [15:0]            half_eff;
   logic [COUNT_WIDTH-1:0] half_lim;
   logic [COUNT_WIDTH-1:0] tick_inc;
   logic                   half_done;

   // zero half period behaves as one tick
   assign half_eff  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
   assign half_lim  = sat_limit(24'(half_eff));
   assign tick_inc  = sat_inc(tick_ff);
   assign half_done = tick_inc >= half_lim;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      pulses_in  = pulses_ff;
      outcome_in = outcome_ff;
      fin        = 1'b0;
      status     = OutCleared;
      case (phase_ff)
         PhIdle: begin
            if (item.start_request) begin
               phase_in = PhSettle;
               tick_in  = '0;
            end
         end
         PhSettle: begin
            if (tick_ff < sat_limit(cfg.settle_ticks)) begin
               tick_in = tick_inc;
            end else if (!item.scl_level) begin
               fin    = 1'b1;
               status = OutSclStuck;
            end else if (item.sda_level) begin
               phase_in = PhStart;
               tick_in  = '0;
            end else if (cfg.max_pulses == 5'd0) begin
               fin    = 1'b1;
               status = OutSdaStuck;
            end else begin
               pulses_in = cfg.max_pulses - 5'd1;
               phase_in  = PhPulseLow;
               tick_in   = '0;
            end
         end
         PhPulseLow: begin
            tick_in = tick_inc;
            if (half_done) begin
               phase_in = PhPulseHigh;
               tick_in  = '0;
            end
         end
         PhPulseHigh: begin
            tick_in = tick_inc;
            if (half_done) begin
               phase_in = PhStretch;
               tick_in  = '0;
            end
         end
         PhStretch: begin
            if (item.scl_level) begin
               if (item.sda_level) begin
                  phase_in = PhStart;
                  tick_in  = '0;
               end else if (pulses_ff != 5'd0) begin
                  pulses_in = pulses_ff - 5'd1;
                  phase_in  = PhPulseLow;
                  tick_in   = '0;
               end else begin
                  fin    = 1'b1;
                  status = OutSdaStuck;
               end
            end else begin
               tick_in = tick_inc;
               if (tick_inc >= sat_limit(cfg.stretch_timeout_ticks)) begin
                  fin    = 1'b1;
                  status = OutStretchTmo;
               end
            end
         end
         PhStart: begin
            tick_in = tick_inc;
            if (half_done) begin
               phase_in = PhStop;
               tick_in  = '0;
            end
         end
         PhStop: begin
            tick_in = tick_inc;
            if (half_done) begin
               fin    = 1'b1;
               status = OutCleared;
            end
         end
         default: begin
            phase_in = PhIdle;
            tick_in  = '0;
         end
      endcase
      if (fin) begin
         outcome_in = status;
         phase_in   = PhIdle;
         tick_in    = '0;
      end
   end

   always_comb begin
      result.scl_drive_low = phase_in == PhPulseLow;
      result.sda_drive_low = phase_in == PhStart;
      result.busy_res      = phase_in != PhIdle;
      result.finished      = fin;
      result.outcome       = outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhIdle;
         tick_ff    <= '0;
         pulses_ff  <= '0;
         outcome_ff <= OutCleared;
      end else if (step) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         pulses_ff  <= pulses_in;
         outcome_ff <= outcome_in;
      end
   end

   a_fin_ends_busy: assert property (@(posedge clock) disable iff (reset)
      step && fin |=> phase_ff == PhIdle && tick_ff == '0)
      else $error("sequence end did not return to idle");

   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(result.scl_drive_low && result.sda_drive_low))
      else $error("both lines driven low");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff) && $stable(outcome_ff))
      else $error("state moved without a word");

   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PhIdle && item.start_request |=> phase_ff == PhSettle)
      else $error("start in idle not taken");

endmodule

@@ tb/tb_i2c_bus_recovery_sequencer_top.sv @@
`timescale 1ns / 1ps

module tb_i2c_bus_recovery_sequencer_top;
   import i2cbr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [31:0] TICK_MAX = (32'd1 << COUNT_WIDTH) - 32'd1;

   typedef enum logic [2:0] {
      SqIdle, SqSettle, SqPulseLow, SqPulseHigh, SqStretch, SqStartCond, SqStopCond
   } seq_phase_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CsrSettle;
   logic [23:0] csr_write_data = '0;

   i2c_bus_recovery_sequencer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tick words waiting to be sent and drive levels the block owes us
   req_type tick_words[$];
   rsp_type predicted_rsp[$];
   rsp_type rsp_want;
   rsp_type rsp_pred;

   int tx_idle_pct = 38;
   int rx_idle_pct = 79;
   int mismatches = 0;
   int words_checked = 0;
   int cycles = 0;
   int finished_by_code[4] = '{0, 0, 0, 0};

   // sequencer mirror
   cfg_type    bus_cfg;
   seq_phase_t sq_phase;
   logic [31:0] sq_ticks;
   logic [4:0]  sq_pulses_left;
   logic [1:0]  sq_outcome;

   function automatic logic [31:0] tick_limit(input logic [31:0] v);
      return (v > TICK_MAX) ? TICK_MAX : v;
   endfunction

   function automatic logic [31:0] tick_bump(input logic [31:0] c);
      return (c >= TICK_MAX) ? TICK_MAX : c + 32'd1;
   endfunction

   function automatic req_type make_word(input bit s, input bit c, input bit d);
      req_type w;
      w.start_request = s;
      w.scl_level = c;
      w.sda_level = d;
      return w;
   endfunction

   task automatic enter_phase(input seq_phase_t p);
      sq_phase = p;
      sq_ticks = '0;
   endtask

   task automatic step_recovery(input req_type w, output rsp_type r);
      logic        done;
      logic [1:0]  code;
      logic [31:0] half_lim;
      done = 1'b0;
      code = OutCleared;
      half_lim = tick_limit((bus_cfg.half_period_ticks == '0) ? 32'd1
                                                               : 32'(bus_cfg.half_period_ticks));
      case (sq_phase)
         SqIdle: begin
            if (w.start_request) enter_phase(SqSettle);
         end
         SqSettle: begin
            if (sq_ticks < tick_limit(32'(bus_cfg.settle_ticks))) begin
               sq_ticks = tick_bump(sq_ticks);
            end else if (!w.scl_level) begin
               done = 1'b1;
               code = OutSclStuck;
            end else if (w.sda_level) begin
               enter_phase(SqStartCond);
            end else if (bus_cfg.max_pulses == '0) begin
               done = 1'b1;
               code = OutSdaStuck;
            end else begin
               sq_pulses_left = bus_cfg.max_pulses - 5'd1;
               enter_phase(SqPulseLow);
            end
         end
         SqPulseLow: begin
            sq_ticks = tick_bump(sq_ticks);
            if (sq_ticks >= half_lim) enter_phase(SqPulseHigh);
         end
         SqPulseHigh: begin
            sq_ticks = tick_bump(sq_ticks);
            if (sq_ticks >= half_lim) enter_phase(SqStretch);
         end
         SqStretch: begin
            if (w.scl_level) begin
               if (w.sda_level) begin
                  enter_phase(SqStartCond);
               end else if (sq_pulses_left != '0) begin
                  sq_pulses_left = sq_pulses_left - 5'd1;
                  enter_phase(SqPulseLow);
               end else begin
                  done = 1'b1;
                  code = OutSdaStuck;
               end
            end else begin
               sq_ticks = tick_bump(sq_ticks);
               if (sq_ticks >= tick_limit(32'(bus_cfg.stretch_timeout_ticks))) begin
                  done = 1'b1;
                  code = OutStretchTmo;
               end
            end
         end
         SqStartCond: begin
            sq_ticks = tick_bump(sq_ticks);
            if (sq_ticks >= half_lim) enter_phase(SqStopCond);
         end
         SqStopCond: begin
            sq_ticks = tick_bump(sq_ticks);
            if (sq_ticks >= half_lim) done = 1'b1;
         end
         default: begin
            enter_phase(SqIdle);
         end
      endcase
      if (done) begin
         sq_outcome = code;
         enter_phase(SqIdle);
      end
      r.scl_drive_low = (sq_phase == SqPulseLow);
      r.sda_drive_low = (sq_phase == SqStartCond);
      r.busy_res = (sq_phase != SqIdle);
      r.finished = done;
      r.outcome = sq_outcome;
   endtask

   // driver: predict on accept, then offer the next word unless idling
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_recovery(req_data, rsp_pred);
            predicted_rsp.push_back(rsp_pred);
         end
         if (!req_valid || !req_stall) begin
            if (tick_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_data <= tick_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: rsp word with nothing expected, actual %p", $time, rsp_data);
            end else begin
               rsp_want = predicted_rsp.pop_front();
               words_checked++;
               if (rsp_data.finished === 1'b1) finished_by_code[rsp_data.outcome]++;
               if (rsp_data !== rsp_want) begin
                  mismatches++;
                  $display({"%0t: rsp mismatch expected scl_lo=%b sda_lo=%b busy=%b fin=%b ",
                            "out=%0d, actual scl_lo=%b sda_lo=%b busy=%b fin=%b out=%0d"},
                           $time, rsp_want.scl_drive_low, rsp_want.sda_drive_low,
                           rsp_want.busy_res, rsp_want.finished, rsp_want.outcome,
                           rsp_data.scl_drive_low, rsp_data.sda_drive_low,
                           rsp_data.busy_res, rsp_data.finished, rsp_data.outcome);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycles, predicted_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CsrSettle:  bus_cfg.settle_ticks = val;
         CsrHalf:    bus_cfg.half_period_ticks = val[15:0];
         CsrStretch: bus_cfg.stretch_timeout_ticks = val;
         CsrPulses:  bus_cfg.max_pulses = val[4:0];
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers carry junk to check the masking
   task automatic program_timing(input logic [23:0] settle, input logic [15:0] half,
                                 input logic [23:0] stretch, input logic [4:0] pulses);
      write_reg(CsrSettle, settle);
      write_reg(CsrHalf, {8'($urandom), half});
      write_reg(CsrStretch, stretch);
      write_reg(CsrPulses, {19'($urandom), pulses});
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (tick_words.size() != 0 || req_valid || predicted_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // keep the lines released until the sequencer is back in idle
   task automatic bring_to_idle();
      wait_quiet();
      while (sq_phase != SqIdle) begin
         repeat (16) tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
         wait_quiet();
      end
   endtask

   task automatic queue_recovery_traffic(input int budget);
      int n;
      int len;
      int scl_pct;
      int sda_pct;
      int sda_free_at;
      int scl_choice[6] = '{100, 100, 97, 80, 40, 0};
      int sda_choice[5] = '{100, 90, 50, 10, 0};
      n = 0;
      while (n < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(4, 60);
            scl_pct = scl_choice[$urandom_range(0, 5)];
            sda_pct = sda_choice[$urandom_range(0, 4)];
            sda_free_at = $urandom_range(0, len + 20);
            tick_words.push_back(make_word(1'b1, 1'($urandom), 1'($urandom)));
            for (int k = 0; k < len; k++) begin
               tick_words.push_back(make_word(
                  $urandom_range(0, 19) == 0,
                  $urandom_range(0, 99) < scl_pct,
                  (k >= sda_free_at) ? ($urandom_range(0, 99) < 90)
                                     : ($urandom_range(0, 99) < sda_pct)));
            end
            n += len + 1;
         end else begin
            len = $urandom_range(1, 10);
            repeat (len) tick_words.push_back(req_type'(3'($urandom)));
            n += len;
         end
      end
   endtask

   initial begin
      bus_cfg.settle_ticks = 24'd2500000;
      bus_cfg.half_period_ticks = 16'd10;
      bus_cfg.stretch_timeout_ticks = 24'd2000000;
      bus_cfg.max_pulses = 5'd20;
      sq_phase = SqIdle;
      sq_ticks = '0;
      sq_pulses_left = '0;
      sq_outcome = OutCleared;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults straight out of reset, no start
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b0, 1'b0, 1'b0));
      wait_quiet();

      program_timing(24'd0, 16'd1, 24'd2, 5'd1);
      // clean bus, with a start landing on the finishing tick
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      // scl held low at the check
      tick_words.push_back(make_word(1'b1, 1'b0, 1'b0));
      tick_words.push_back(make_word(1'b0, 1'b0, 1'b1));
      // sda stuck through the only pulse
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b0));
      repeat (4) tick_words.push_back(make_word(1'b0, 1'b1, 1'b0));
      // scl stretched past the timeout
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b0));
      repeat (3) tick_words.push_back(make_word(1'b0, 1'b1, 1'b0));
      repeat (2) tick_words.push_back(make_word(1'b0, 1'b0, 1'b0));
      // sda frees after one pulse, busy start ignored
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b0));
      repeat (3) tick_words.push_back(make_word(1'b0, 1'b1, 1'b0));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b1));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      bring_to_idle();

      for (int ph = 0; ph < 12; ph++) begin
         tx_idle_pct = (ph < 4) ? 38 : (ph < 8) ? 79 : 0;
         rx_idle_pct = (ph < 4) ? 79 : (ph < 8) ? 38 : 0;
         if (ph == 0) begin
            // zero half period, zero stretch timeout, zero pulses
            program_timing(24'd0, 16'd0, 24'd0, 5'd0);
         end else if (ph == 1) begin
            program_timing(24'($urandom_range(0, 3)), 16'd1, 24'd3, 5'd31);
         end else begin
            program_timing(24'($urandom_range(0, 6)),
                           ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                           24'($urandom_range(0, 8)), 5'($urandom_range(0, 6)));
         end
         queue_recovery_traffic(100);
         bring_to_idle();
      end

      // widest settings: idle words only under the longest settle
      program_timing(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 5'd31);
      repeat (8) tick_words.push_back(make_word(1'b0, 1'($urandom), 1'($urandom)));
      wait_quiet();
      // short settle and half period, widest stretch timeout and pulse count
      write_reg(CsrSettle, 24'd0);
      write_reg(CsrHalf, 24'd2);
      @(negedge clock);
      tick_words.push_back(make_word(1'b1, 1'b1, 1'b0));
      repeat (5) tick_words.push_back(make_word(1'b0, 1'b1, 1'b0));
      repeat (3) tick_words.push_back(make_word(1'b0, 1'b0, 1'b0));
      tick_words.push_back(make_word(1'b0, 1'b1, 1'b1));
      bring_to_idle();

      repeat (8) @(negedge clock);
      $display("checked %0d rsp words over directed cases, %s", words_checked,
               "12 random setting phases and the widest timing");
      $display("sequences ended: cleared %0d, scl stuck %0d, stretch timeout %0d, sda stuck %0d",
               finished_by_code[OutCleared], finished_by_code[OutSclStuck],
               finished_by_code[OutStretchTmo], finished_by_code[OutSdaStuck]);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
